FILE: design/amt_pkg.sv
// Shared widths, codes and types for the address map table.
package amt_pkg;

   // Field widths fixed by the item format
   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int ADDR_W   = 16;
   localparam int SEEN_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int COUNT_W  = 7;

   // Operation codes carried on the request channel
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2
   } amt_op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_UPDATED   = 3'd0,
      STATUS_ADDED     = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_FOUND     = 3'd3,
      STATUS_NOT_FOUND = 3'd4,
      STATUS_REMOVED   = 3'd5
   } amt_status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_MOVE,
      ST_OUT
   } amt_state_type;

   // One table entry as held in the memory
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] addr;
      logic [SEEN_W-1:0] seen;
   } amt_entry_type;

endpackage

FILE: design/amt_req_if.sv
// Request channel: valid/ready handshake with the operation payload.
interface amt_req_if
   import amt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [KEY_W-1:0]  device_key;
   logic [ADDR_W-1:0] short_addr;
   logic [SEEN_W-1:0] now_ms;

   modport source (output valid, output op, output device_key, output short_addr,
                   output now_ms, input ready);
   modport sink   (input valid, input op, input device_key, input short_addr,
                   input now_ms, output ready);
endinterface

FILE: design/amt_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
interface amt_rsp_if
   import amt_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [ADDR_W-1:0]   found_addr;
   logic [SEEN_W-1:0]   found_seen_ms;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output slot, output found_addr,
                   output found_seen_ms, output entry_count, input ready);
   modport sink   (input valid, input status, input slot, input found_addr,
                   input found_seen_ms, input entry_count, output ready);
endinterface

FILE: design/address_map_table.sv
// Address map table: keyed store of short address and last-seen time.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------
//   req_ch  | in  | op, device_key, short_addr, now_ms
//   rsp_ch  | out | status, slot, found_addr, found_seen_ms, entry_count
//
// One item at a time. Entries live in one memory with a registered read port;
// the key search reads one entry per cycle from slot 0 upward. A hit goes from
// ST_SCAN to ST_OUT, a miss passes through ST_MISS first; a remove that moves the
// last entry into the hole passes through ST_MOVE as well. Reset (synchronous)
// empties the table by clearing the count; memory contents are left as is.
// A new request is taken while the previous response still waits in the output
// register; a result only stalls in ST_OUT when that register is still full.
module address_map_table
   import amt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   amt_req_if.sink   req_ch,
   amt_rsp_if.source rsp_ch
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Entry memory and its registered read port
   amt_entry_type mem [DEPTH];
   amt_entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   amt_entry_type    wr_data;

   // Control state
   amt_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;

   // Captured request
   amt_op_type        op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SEEN_W-1:0] now_ff;

   // Pending result
   amt_status_type    res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_slot_ff, res_slot_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [SEEN_W-1:0] res_seen_ff, res_seen_in;

   // Output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [SEEN_W-1:0]   rsp_seen_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic             req_fire;
   logic             rsp_load;
   logic             key_match;
   logic [CNT_W-1:0] idx_next;
   logic [CNT_W-1:0] last_idx;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign key_match    = (rd_data_ff.key == key_ff);
   assign idx_next     = idx_ff + CNT_W'(1);
   assign last_idx     = count_ff - CNT_W'(1);

   // Next state, memory access and result selection
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hit_idx_in    = hit_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_addr_in   = res_addr_ff;
      res_seen_in   = res_seen_ff;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = '{key: key_ff, addr: addr_ff, seen: now_ff};
      rsp_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            idx_in  = '0;
            rd_addr = '0;
            if (req_fire) begin
               state_in = (count_ff == '0) ? ST_MISS : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (key_match) begin
               hit_idx_in  = idx_ff[IDX_W-1:0];
               res_slot_in = idx_ff[IDX_W-1:0];
               state_in    = ST_OUT;
               case (op_ff)
                  OP_INSERT: begin
                     wr_en         = 1'b1;
                     res_status_in = STATUS_UPDATED;
                     res_addr_in   = addr_ff;
                     res_seen_in   = now_ff;
                  end
                  OP_LOOKUP: begin
                     res_status_in = STATUS_FOUND;
                     res_addr_in   = rd_data_ff.addr;
                     res_seen_in   = rd_data_ff.seen;
                  end
                  OP_REMOVE: begin
                     res_status_in = STATUS_REMOVED;
                     res_addr_in   = rd_data_ff.addr;
                     res_seen_in   = rd_data_ff.seen;
                     count_in      = last_idx;
                     // hole below the tail: fetch the tail entry to fill it
                     if (idx_ff < last_idx) begin
                        rd_addr  = last_idx[IDX_W-1:0];
                        state_in = ST_MOVE;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_NOT_FOUND;
                     res_slot_in   = '0;
                     res_addr_in   = '0;
                     res_seen_in   = '0;
                  end
               endcase
            end else if (idx_next >= count_ff) begin
               state_in = ST_MISS;
            end else begin
               idx_in  = idx_next;
               rd_addr = idx_next[IDX_W-1:0];
            end
         end

         ST_MISS: begin
            state_in      = ST_OUT;
            res_status_in = STATUS_NOT_FOUND;
            res_slot_in   = '0;
            res_addr_in   = '0;
            res_seen_in   = '0;
            if (op_ff == OP_INSERT) begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  // append at the tail
                  wr_en         = 1'b1;
                  wr_addr       = count_ff[IDX_W-1:0];
                  count_in      = count_ff + CNT_W'(1);
                  res_status_in = STATUS_ADDED;
                  res_slot_in   = count_ff[IDX_W-1:0];
                  res_addr_in   = addr_ff;
                  res_seen_in   = now_ff;
               end
            end
         end

         ST_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = hit_idx_ff;
            wr_data  = rd_data_ff;
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, scan position and result payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hit_idx_ff    <= hit_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_addr_ff   <= res_addr_in;
      res_seen_ff   <= res_seen_in;
      if (req_fire) begin
         op_ff   <= amt_op_type'(req_ch.op);
         key_ff  <= req_ch.device_key;
         addr_ff <= req_ch.short_addr;
         now_ff  <= req_ch.now_ms;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= SLOT_W'(res_slot_ff);
         rsp_addr_ff   <= res_addr_ff;
         rsp_seen_ff   <= res_seen_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.slot          = rsp_slot_ff;
   assign rsp_ch.found_addr    = rsp_addr_ff;
   assign rsp_ch.found_seen_ms = rsp_seen_ff;
   assign rsp_ch.entry_count   = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff < count_ff)
      else $error("scan index past the last valid entry");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_SCAN || state_ff == ST_MISS)
      else $error("accepted request did not start a search");

   a_count_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_OUT) |=> count_ff == $past(count_ff))
      else $error("entry count changed outside an operation");

   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result load did not present a response");

endmodule

FILE: tb/address_map_table_test.sv
// Self-checking testbench for the address map table: directed and random request beats.
`timescale 1ns / 1ps

module address_map_table_test;
   import amt_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int POOL_SIZE    = 96;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 200;
   localparam int SETTLE_CYCLES = 80;

   // Op code outside the decoded set; the block must treat it as a miss
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Traffic shapes for the random part
   localparam int MODE_FILL  = 0;
   localparam int MODE_MIX   = 1;
   localparam int MODE_DRAIN = 2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   addr;
      logic [SEEN_W-1:0]   seen;
      logic [COUNT_W-1:0]  count;
   } table_rsp_type;

   // Shadow copy of the table and the queue of responses it predicts
   class table_scoreboard;
      logic [KEY_W-1:0]  keys  [TABLE_DEPTH];
      logic [ADDR_W-1:0] addrs [TABLE_DEPTH];
      logic [SEEN_W-1:0] seens [TABLE_DEPTH];
      int unsigned       used;
      table_rsp_type     pending_rsp[$];
      int                errors;

      function int find_slot(logic [KEY_W-1:0] key);
         for (int i = 0; i < used; i++)
            if (keys[i] == key) return i;
         return -1;
      endfunction

      function logic [KEY_W-1:0] stored_key();
         return keys[$urandom_range(0, used - 1)];
      endfunction

      // Apply one accepted request to the shadow table
      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [ADDR_W-1:0] addr, logic [SEEN_W-1:0] now);
         int            hit;
         int            last;
         table_rsp_type r;
         hit = find_slot(key);
         r = '0;
         r.status = STATUS_NOT_FOUND;
         case (op)
            OP_INSERT: begin
               if (hit >= 0) begin
                  addrs[hit] = addr;
                  seens[hit] = now;
                  r.status = STATUS_UPDATED;
                  r.slot = SLOT_W'(hit);
                  r.addr = addr;
                  r.seen = now;
               end else if (used >= TABLE_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  keys[used]  = key;
                  addrs[used] = addr;
                  seens[used] = now;
                  r.status = STATUS_ADDED;
                  r.slot = SLOT_W'(used);
                  r.addr = addr;
                  r.seen = now;
                  used++;
               end
            end
            OP_LOOKUP: begin
               if (hit >= 0) begin
                  r.status = STATUS_FOUND;
                  r.slot = SLOT_W'(hit);
                  r.addr = addrs[hit];
                  r.seen = seens[hit];
               end
            end
            OP_REMOVE: begin
               if (hit >= 0) begin
                  last = used - 1;
                  r.status = STATUS_REMOVED;
                  r.slot = SLOT_W'(hit);
                  r.addr = addrs[hit];
                  r.seen = seens[hit];
                  // last entry fills the hole
                  if (hit < last) begin
                     keys[hit]  = keys[last];
                     addrs[hit] = addrs[last];
                     seens[hit] = seens[last];
                  end
                  used = last;
               end
            end
            default: ;
         endcase
         r.count = COUNT_W'(used);
         pending_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         end
      endfunction

      // Match one response beat against the oldest prediction
      function void check_response(table_rsp_type got);
         table_rsp_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing expected, got status %0d",
                     $time, got.status);
            return;
         end
         want = pending_rsp.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("slot", want.slot, got.slot);
         compare_field("found_addr", want.addr, got.addr);
         compare_field("found_seen_ms", want.seen, got.seen);
         compare_field("entry_count", want.count, got.count);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   amt_req_if req_ch ();
   amt_rsp_if rsp_ch ();

   address_map_table #(.DEPTH(TABLE_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   table_scoreboard  board;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   bit               calm;
   int               rsp_stall;
   table_rsp_type    rsp_beat;

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Response side: check accepted beats, stall ready at random
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_beat = '{rsp_ch.status, rsp_ch.slot, rsp_ch.found_addr,
                      rsp_ch.found_seen_ms, rsp_ch.entry_count};
         board.check_response(rsp_beat);
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!calm && $urandom_range(0, 2) == 0) rsp_stall = pick_gap();
      end
   end

   // One request beat, after an optional idle gap
   task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [ADDR_W-1:0] addr, input logic [SEEN_W-1:0] now);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.device_key <= key;
      req_ch.short_addr <= addr;
      req_ch.now_ms     <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(op, key, addr, now);
   endtask

   // Hold off requests until every predicted response has come back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] pick_addr();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
      return ADDR_W'($urandom);
   endfunction

   function automatic logic [SEEN_W-1:0] pick_time();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
      return $urandom;
   endfunction

   // Random beat shaped by the traffic mode
   task automatic random_item(input int mode);
      int               r;
      int               k;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  op = r < 80 ? OP_INSERT : r < 92 ? OP_LOOKUP : r < 97 ? OP_REMOVE : OP_UNUSED;
         MODE_DRAIN: op = r < 15 ? OP_INSERT : r < 35 ? OP_LOOKUP : r < 97 ? OP_REMOVE : OP_UNUSED;
         default:    op = r < 40 ? OP_INSERT : r < 70 ? OP_LOOKUP : r < 96 ? OP_REMOVE : OP_UNUSED;
      endcase
      k = $urandom_range(0, 99);
      if (op != OP_INSERT && board.used > 0 && k < 60) key = board.stored_key();
      else if (k < 92) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = {$urandom, $urandom};
      send_req(op, key, pick_addr(), pick_time());
   endtask

   initial begin
      int mode;
      board = new();
      calm = 1'b0;
      rsp_stall = 0;
      reset <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_INSERT;
      req_ch.device_key <= '0;
      req_ch.short_addr <= '0;
      req_ch.now_ms     <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, update, swap on remove, unused op
      send_req(OP_LOOKUP, key_pool[0], '0, '0);
      send_req(OP_REMOVE, key_pool[0], '0, '0);
      send_req(OP_UNUSED, key_pool[1], '1, '1);
      send_req(OP_INSERT, key_pool[0], '0, '0);
      send_req(OP_INSERT, key_pool[1], '1, '1);
      send_req(OP_INSERT, key_pool[2], 16'h1234, 32'h0000_8000);
      send_req(OP_INSERT, key_pool[3], 16'h8001, 32'h7fff_ffff);
      send_req(OP_INSERT, key_pool[0], '1, '1);
      send_req(OP_LOOKUP, key_pool[1], '0, '0);
      send_req(OP_LOOKUP, key_pool[3], '0, '0);
      send_req(OP_LOOKUP, key_pool[4], '0, '0);
      send_req(OP_REMOVE, key_pool[0], '0, '0);
      send_req(OP_LOOKUP, key_pool[3], '0, '0);
      send_req(OP_REMOVE, key_pool[3], '0, '0);
      send_req(OP_REMOVE, key_pool[1], '0, '0);
      send_req(OP_REMOVE, key_pool[1], '0, '0);
      send_req(OP_UNUSED, key_pool[2], 16'h0f0f, 32'h1);
      send_req(OP_LOOKUP, key_pool[2], '0, '0);
      send_req(OP_REMOVE, key_pool[2], '0, '0);
      send_req(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 16'h5555, 32'haaaa_aaaa);
      send_req(OP_INSERT, 64'h5555_5555_5555_5555, 16'haaaa, 32'h5555_5555);
      send_req(OP_REMOVE, 64'haaaa_aaaa_aaaa_aaaa, '0, '0);
      send_req(OP_LOOKUP, 64'h5555_5555_5555_5555, '0, '0);
      wait_for_drain();

      // Random: alternate filling to full, mixed traffic and draining
      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase % 4 == 3);
         mode = phase % 3 == 0 ? MODE_FILL : phase % 3 == 1 ? MODE_MIX : MODE_DRAIN;
         repeat (PHASE_ITEMS) random_item(mode);
         wait_for_drain();
      end
      calm = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("address_map_table_test OK");
      end else begin
         $display("address_map_table_test NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #15_000_000;
      $display("address_map_table_test NOT OK");
      $finish;
   end

endmodule
